### rtl/tac_pkg.sv
// Shared constants of the thermistor temperature converter: field widths,
// fixed-point constants of the beta equation and pipeline latencies.
// No dependencies.
`default_nettype none

package tac_pkg;

  // field widths
  localparam int ADC_BITS_DEF = 10;
  localparam int CODE_W       = 10;
  localparam int TEMP_W       = 11;
  localparam int VAL_W        = 11;
  localparam int B_W          = 14;

  localparam logic [B_W-1:0] B_RESET = 14'd3950;

  // special result values
  localparam logic signed [VAL_W-1:0] VAL_ERR    = -11'sd999;
  localparam logic signed [VAL_W-1:0] VAL_ABS0   = -11'sd272;
  localparam logic signed [VAL_W-1:0] VAL_MAX    = 11'sd1023;
  localparam logic signed [VAL_W-1:0] VAL_MIN    = -11'sd1024;
  localparam logic signed [VAL_W-1:0] COLD_LIMIT = -11'sd100;

  // fixed-point constants
  localparam logic [63:0]  LN2_Q62   = 64'h2C5C85FDF473DE6B;
  localparam logic [63:0]  LOG2E_Q62 = 64'h5C551D94AE0BF85E;
  localparam logic [63:0]  C273_Q32  = ((64'd5463 << 32) + 64'd10) / 64'd20;
  localparam logic [63:0]  T0_Q32    = 64'd25 * (64'd1 << 32) + C273_Q32;
  localparam logic [127:0] K58_W     = (128'd1 << 90) / {64'd0, T0_Q32};
  localparam logic [63:0]  K58       = K58_W[63:0];

  // unit sizes and latencies
  localparam int MUL_LAT = 2;
  localparam int LN_ITER = 48;
  localparam int LN_LAT  = 1 + LN_ITER * MUL_LAT + MUL_LAT;
  localparam int TA_QB   = 64;
  localparam int XA_DW   = 62;
  localparam int XA_QB   = 44;
  localparam int INV_DW  = 43;
  localparam int INV_QB  = 51;
  localparam int SER_N   = 24;
  localparam int Q_DW    = 64;
  localparam int Q_QB    = 48;
  localparam int KW_EXP  = 8;

  localparam int FWD_LAT = LN_LAT + 1 + TA_QB + 1 + XA_QB + 1;
  localparam int INV_LAT = INV_QB + 1 + 3 * MUL_LAT + SER_N * (2 * MUL_LAT)
                         + 1 + Q_QB + 1;

endpackage

`default_nettype wire

### rtl/tac_if.sv
// Valid/ready channels of the thermistor converter: input items and result items.
// Depends on tac_pkg for the field widths.
`default_nettype none

interface tac_in_if;
  logic                              valid;
  logic                              ready;
  logic                              func;
  logic [tac_pkg::CODE_W-1:0]        adc_code;
  logic signed [tac_pkg::TEMP_W-1:0] temperature_in;

  modport source (output valid, func, adc_code, temperature_in, input ready);
  modport sink   (input valid, func, adc_code, temperature_in, output ready);
endinterface

interface tac_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [tac_pkg::VAL_W-1:0] value;
  logic                             error;

  modport source (output valid, value, error, input ready);
  modport sink   (input valid, value, error, output ready);
endinterface

`default_nettype wire

### rtl/tac_dly.sv
// Enabled delay line of N register stages for side data travelling with an item.
// No dependencies.
`default_nettype none

module tac_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [N];

  // shift on every enabled cycle
  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < N; i++) sr_r[i] <= sr_r[i-1];
    end
  end

  assign q = sr_r[N-1];

endmodule

`default_nettype wire

### rtl/tac_mul.sv
// Two-stage 64 x 64 multiplier returning bits [S+63:S] of the product.
// Stage one holds four 32 x 32 partial products, stage two the sum.
`default_nettype none

module tac_mul #(
  parameter int S = 61
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);

  logic [63:0]  ll_r, lh_r, hl_r, hh_r;
  logic [127:0] full;

  // partial products
  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= a[31:0]  * b[31:0];
      lh_r <= a[31:0]  * b[63:32];
      hl_r <= a[63:32] * b[31:0];
      hh_r <= a[63:32] * b[63:32];
    end
  end

  assign full = {64'd0, ll_r} + ({64'd0, lh_r} << 32) + ({64'd0, hl_r} << 32)
              + {hh_r, 64'd0};

  always_ff @(posedge clk) begin
    if (en) p <= full[S+63:S];
  end

endmodule

`default_nettype wire

### rtl/tac_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// q = floor(({hi, lo}) / den), provided hi < den; den travels with the item.
`default_nettype none

module tac_div #(
  parameter int DW = 14,
  parameter int QB = 64
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] hi,
  input  logic [QB-1:0] lo,
  input  logic [DW-1:0] den,
  output logic [QB-1:0] q
);

  logic [DW-1:0] rem_r [QB];
  logic [QB-1:0] num_r [QB];
  logic [QB-1:0] quo_r [QB];
  logic [DW-1:0] den_r [QB];

  for (genvar j = 0; j < QB; j++) begin : g_st
    logic [DW-1:0] rem_i, den_i;
    logic [QB-1:0] num_i, quo_i;
    logic [DW:0]   t;
    logic          ge;

    if (j == 0) begin : g_first
      assign rem_i = hi;
      assign num_i = lo;
      assign quo_i = '0;
      assign den_i = den;
    end else begin : g_next
      assign rem_i = rem_r[j-1];
      assign num_i = num_r[j-1];
      assign quo_i = quo_r[j-1];
      assign den_i = den_r[j-1];
    end

    // bring down one dividend bit, subtract if it fits
    assign t  = {rem_i, num_i[QB-1]};
    assign ge = t >= {1'b0, den_i};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? DW'(t - {1'b0, den_i}) : t[DW-1:0];
        num_r[j] <= {num_i[QB-2:0], 1'b0};
        quo_r[j] <= {quo_i[QB-2:0], ge};
        den_r[j] <= den_i;
      end
    end
  end

  assign q = quo_r[QB-1];

endmodule

`default_nettype wire

### rtl/tac_ln.sv
// Pipelined natural logarithm of a positive integer, Q48 result.
// 48 squaring stages extract log2 bits, then a multiply by ln 2. Uses tac_mul, tac_dly.
`default_nettype none

module tac_ln #(
  parameter int NW = 10
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] n,
  output logic [63:0]   ln
);

  import tac_pkg::*;

  localparam int KW = $clog2(NW);

  logic [KW-1:0] k, k_r, k_d;
  logic [63:0]   m0, m_r;

  wire  [63:0]   m_in   [LN_ITER+1];
  wire  [47:0]   acc_in [LN_ITER+1];

  // leading one position and normalised mantissa in [2^61, 2^62)
  always_comb begin
    k = '0;
    for (int i = 0; i < NW; i++) begin
      if (n[i]) k = KW'(i);
    end
    m0 = {{(64-NW){1'b0}}, n} << (7'd61 - 7'(k));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k_r <= k;
      m_r <= m0;
    end
  end

  assign m_in[0]   = m_r;
  assign acc_in[0] = '0;

  // one fractional bit of log2 per squaring
  for (genvar i = 0; i < LN_ITER; i++) begin : g_sq
    logic [63:0] p;
    logic [47:0] acc_d;
    logic        bitv;

    tac_mul #(.S(61)) u_sq (
      .clk(clk), .en(en), .a(m_in[i]), .b(m_in[i]), .p(p)
    );
    tac_dly #(.W(48), .N(MUL_LAT)) u_acc (
      .clk(clk), .en(en), .d(acc_in[i]), .q(acc_d)
    );

    assign bitv        = p[63] | p[62];
    assign m_in[i+1]   = bitv ? (p >> 1) : p;
    assign acc_in[i+1] = {acc_d[46:0], bitv};
  end

  tac_dly #(.W(KW), .N(LN_ITER * MUL_LAT)) u_k (
    .clk(clk), .en(en), .d(k_r), .q(k_d)
  );

  // log2 to natural log
  tac_mul #(.S(62)) u_ln2 (
    .clk(clk), .en(en),
    .a({{(16-KW){1'b0}}, k_d, acc_in[LN_ITER]}),
    .b(LN2_Q62),
    .p(ln)
  );

endmodule

`default_nettype wire

### rtl/tac_fwd.sv
// ADC code to Celsius path: ln ratio, divide by beta, add 1/T0, reciprocal, round.
// Uses tac_ln, tac_div, tac_dly and constants of tac_pkg.
`default_nettype none

module tac_fwd #(
  parameter int ADC_BITS = tac_pkg::ADC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [tac_pkg::CODE_W-1:0]       code,
  input  logic [tac_pkg::B_W-1:0]          b_coef,
  output logic signed [tac_pkg::VAL_W-1:0] value,
  output logic                             err
);

  import tac_pkg::*;

  localparam logic [16:0] FULL = 17'((18'd1 << ADC_BITS) - 18'd1);

  logic [1:0]  spec, spec_d;
  logic [63:0] ln1, ln2, l, la, ta, xa, x, ta_s;
  logic [63:0] la10_r, xa_r;
  logic        neg_r, neg_d, xneg_r, tiny_r, xneg_d, tiny_d, tiny;
  logic [XA_QB-1:0] tk;

  logic signed [63:0]      tk_s, v32, vr;
  logic [63:0]             mag;
  logic signed [32:0]      q33;
  logic signed [VAL_W-1:0] rnd, value_nxt, value_r;
  logic                    err_r;

  // code zero is an error, code at full scale or beta zero gives absolute zero
  assign spec = {code == '0, ({7'd0, code} >= FULL) || (b_coef == '0)};

  tac_dly #(.W(2), .N(FWD_LAT - 1)) u_spec (
    .clk(clk), .en(en), .d(spec), .q(spec_d)
  );

  tac_ln #(.NW(ADC_BITS)) u_ln1 (
    .clk(clk), .en(en), .n(ADC_BITS'(FULL - {7'd0, code})), .ln(ln1)
  );
  tac_ln #(.NW(ADC_BITS)) u_ln2 (
    .clk(clk), .en(en), .n(ADC_BITS'(code)), .ln(ln2)
  );

  // magnitude of ln(r), scaled for the divide by beta
  assign l  = ln1 - ln2;
  assign la = l[63] ? 64'(-l) : l;

  always_ff @(posedge clk) begin
    if (en) begin
      la10_r <= {la[53:0], 10'd0};
      neg_r  <= l[63];
    end
  end

  tac_div #(.DW(B_W), .QB(TA_QB)) u_ta (
    .clk(clk), .en(en), .hi('0), .lo(la10_r), .den(b_coef), .q(ta)
  );
  tac_dly #(.W(1), .N(TA_QB)) u_neg (
    .clk(clk), .en(en), .d(neg_r), .q(neg_d)
  );

  // 1/T = 1/T0 + ln(r)/B
  assign ta_s = neg_d ? 64'(-ta) : ta;
  assign x    = K58 + ta_s;
  assign xa   = x[63] ? 64'(-x) : x;
  assign tiny = xa <= (64'd1 << 46);

  always_ff @(posedge clk) begin
    if (en) begin
      xa_r   <= xa;
      xneg_r <= x[63];
      tiny_r <= tiny;
    end
  end

  tac_div #(.DW(XA_DW), .QB(XA_QB)) u_tk (
    .clk(clk), .en(en), .hi(XA_DW'(1) << 46), .lo('0), .den(xa_r[XA_DW-1:0]), .q(tk)
  );
  tac_dly #(.W(2), .N(XA_QB)) u_xf (
    .clk(clk), .en(en), .d({xneg_r, tiny_r}), .q({xneg_d, tiny_d})
  );

  // kelvin to Celsius, truncate x + 0.5 toward zero, saturate
  always_comb begin
    tk_s = xneg_d ? -$signed({20'd0, tk}) : $signed({20'd0, tk});
    v32  = tk_s - $signed(C273_Q32);
    vr   = v32 + 64'sd2147483648;
    mag  = vr[63] ? 64'(-vr) : 64'(vr);
    q33  = vr[63] ? -$signed({1'b0, mag[63:32]}) : $signed({1'b0, mag[63:32]});
    if (q33 > 33'sd1023)       rnd = VAL_MAX;
    else if (q33 < -33'sd1024) rnd = VAL_MIN;
    else                       rnd = q33[VAL_W-1:0];

    if (spec_d[1])    value_nxt = VAL_ERR;
    else if (spec_d[0]) value_nxt = VAL_ABS0;
    else if (tiny_d)  value_nxt = xneg_d ? VAL_MIN : VAL_MAX;
    else              value_nxt = rnd;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value_r <= value_nxt;
      err_r   <= spec_d[1];
    end
  end

  assign value = value_r;
  assign err   = err_r;

endmodule

`default_nettype wire

### rtl/tac_inv.sv
// Celsius to ADC code path: 1/T - 1/T0, times beta, exp by 2^k and a 24-term
// series, then FULL / (e + 1). Uses tac_mul, tac_div, tac_dly and tac_pkg.
`default_nettype none

module tac_inv #(
  parameter int ADC_BITS = tac_pkg::ADC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [tac_pkg::TEMP_W-1:0] temp,
  input  logic [tac_pkg::B_W-1:0]           b_coef,
  output logic signed [tac_pkg::VAL_W-1:0]  value
);

  import tac_pkg::*;

  localparam logic [16:0] FULL = 17'((18'd1 << ADC_BITS) - 18'd1);
  localparam logic signed [VAL_W-1:0] SAT_FULL =
    (FULL > 17'd1023) ? VAL_MAX : VAL_W'(FULL);
  localparam int OFS_Z = INV_QB + 1 + MUL_LAT;
  localparam int SER_LAT = 2 * MUL_LAT;
  localparam int N_K   = MUL_LAT + SER_N * SER_LAT;

  logic              cold, cold_z, cold_d, hot, csat, hot_d, csat_d;
  logic [63:0]       t32, y, ya_r, za, wa, g, e40, sh, den_r;
  logic [INV_QB-1:0] inv;
  logic              yneg_r, yneg_d, yneg_d2;
  logic [KW_EXP-1:0] k, k_d;
  logic [47:0]       f;
  logic [Q_QB-1:0]   quo;
  logic [63:0]       qs;
  logic signed [VAL_W-1:0] value_nxt, value_r;

  wire  [63:0] term_w [SER_N+1];
  wire  [63:0] sum_w  [SER_N+1];
  wire  [63:0] g_w    [SER_N];

  // kelvin in Q32; cold items take a harmless divisor
  assign cold = temp < COLD_LIMIT;
  assign t32  = cold ? T0_Q32 : ({{21{temp[TEMP_W-1]}}, temp, 32'd0} + C273_Q32);

  tac_div #(.DW(INV_DW), .QB(INV_QB)) u_inv (
    .clk(clk), .en(en), .hi(INV_DW'(1) << 39), .lo('0), .den(t32[INV_DW-1:0]), .q(inv)
  );

  // y = 1/T - 1/T0
  assign y = {{(64-INV_QB){1'b0}}, inv} - K58;

  always_ff @(posedge clk) begin
    if (en) begin
      ya_r   <= y[63] ? 64'(-y) : y;
      yneg_r <= y[63];
    end
  end

  tac_mul #(.S(10)) u_z (
    .clk(clk), .en(en), .a(ya_r), .b({50'd0, b_coef}), .p(za)
  );
  tac_dly #(.W(1), .N(MUL_LAT)) u_yn1 (
    .clk(clk), .en(en), .d(yneg_r), .q(yneg_d)
  );
  tac_dly #(.W(1), .N(OFS_Z)) u_cold (
    .clk(clk), .en(en), .d(cold), .q(cold_z)
  );

  // exponent out of range on either side
  assign hot  = !yneg_d && (za >= (64'd12 << 48));
  assign csat = yneg_d && (za >= (64'd32 << 48));

  tac_dly #(.W(3), .N(INV_LAT - 1 - OFS_Z)) u_flags (
    .clk(clk), .en(en), .d({cold_z, hot, csat}), .q({cold_d, hot_d, csat_d})
  );

  tac_mul #(.S(62)) u_w (
    .clk(clk), .en(en), .a(za), .b(LOG2E_Q62), .p(wa)
  );
  tac_dly #(.W(1), .N(MUL_LAT)) u_yn2 (
    .clk(clk), .en(en), .d(yneg_d), .q(yneg_d2)
  );

  // split z*log2(e) into integer k and fraction f in [0, 1)
  always_comb begin
    k = KW_EXP'(wa[63:48]);
    f = wa[47:0];
    if (yneg_d2) begin
      k = KW_EXP'(-k);
      if (f != '0) begin
        k = KW_EXP'(k - 1'b1);
        f = 48'((49'd1 << 48) - {1'b0, f});
      end
    end
  end

  tac_mul #(.S(50)) u_g (
    .clk(clk), .en(en), .a({16'd0, f}), .b(LN2_Q62), .p(g)
  );
  tac_dly #(.W(KW_EXP), .N(N_K)) u_k (
    .clk(clk), .en(en), .d(k), .q(k_d)
  );

  assign term_w[0] = 64'd1 << 60;
  assign sum_w[0]  = 64'd1 << 60;
  assign g_w[0]    = g;

  // exp(g) series, term_i = term_(i-1) * g / i
  for (genvar i = 0; i < SER_N; i++) begin : g_ser
    // rounded-up reciprocal of i + 1; exact for products below 2^60
    localparam int          DIV_L = $clog2(i + 1);
    localparam logic [63:0] DIV_M =
      64'(((128'd1 << (60 + DIV_L)) + 128'(i)) / 128'(i + 1));
    logic [63:0] prod, quo_m, sum_d;

    tac_mul #(.S(60)) u_tm (
      .clk(clk), .en(en), .a(term_w[i]), .b(g_w[i]), .p(prod)
    );
    tac_mul #(.S(60)) u_td (
      .clk(clk), .en(en), .a(prod), .b(DIV_M), .p(quo_m)
    );
    assign term_w[i+1] = quo_m >> DIV_L;

    tac_dly #(.W(64), .N(SER_LAT)) u_sum (
      .clk(clk), .en(en), .d(sum_w[i]), .q(sum_d)
    );
    assign sum_w[i+1] = sum_d + term_w[i+1];

    if (i < SER_N - 1) begin : g_gd
      tac_dly #(.W(64), .N(SER_LAT)) u_gd (
        .clk(clk), .en(en), .d(g_w[i]), .q(g_w[i+1])
      );
    end
  end

  // scale by 2^k and add one
  assign e40 = sum_w[SER_N] >> 20;
  assign sh  = k_d[KW_EXP-1] ? (e40 >> KW_EXP'(-k_d)) : (e40 << k_d);

  always_ff @(posedge clk) begin
    if (en) den_r <= sh + (64'd1 << 40);
  end

  tac_div #(.DW(Q_DW), .QB(Q_QB)) u_q (
    .clk(clk), .en(en), .hi({47'd0, FULL} << 24), .lo('0), .den(den_r), .q(quo)
  );

  // round and pick the special cases
  always_comb begin
    qs = ({{(64-Q_QB){1'b0}}, quo} + (64'd1 << 31)) >> 32;
    if (cold_d || hot_d)   value_nxt = '0;
    else if (csat_d)       value_nxt = SAT_FULL;
    else if (qs > 64'd1023) value_nxt = VAL_MAX;
    else                   value_nxt = qs[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

`default_nettype wire

### rtl/thermistor_adc_temperature_convert.sv
// Thermistor beta-equation converter, ADC code <-> Celsius, one item per cycle unless the output stalls.
// Result offered after the input register, the 210-stage forward path and the output
// register; the 204-stage inverse path is padded.
// The forward length is set by the 99-stage log and the 64- and 44-stage divides.
// A stalled output freezes the whole pipeline.
// Reset (synchronous, rst_n low) clears all valid bits and sets B to 3950.
`default_nettype none

module thermistor_adc_temperature_convert #(
  parameter int ADC_BITS = tac_pkg::ADC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [tac_pkg::B_W-1:0]  cfg_wr_data,
  tac_in_if.sink                   in_ch,
  tac_out_if.source                out_ch
);

  import tac_pkg::*;

  logic                     en, in_fire;
  logic [B_W-1:0]           b_r;
  logic                     func_r, func_d;
  logic [CODE_W-1:0]        code_r;
  logic signed [TEMP_W-1:0] temp_r;
  logic [FWD_LAT:0]         vld_r;
  logic signed [VAL_W-1:0]  val_f, val_i, val_id, value_r;
  logic                     err_f, err_r, out_vld_r;

  // global advance: the output register is free or being emptied
  assign en      = !out_vld_r || out_ch.ready;
  assign in_fire = in_ch.valid && en;
  assign in_ch.ready = en;

  // beta register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r <= B_RESET;
    end else if (cfg_wr_en) begin
      b_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (en) begin
      func_r <= in_ch.func;
      code_r <= in_ch.adc_code;
      temp_r <= in_ch.temperature_in;
    end
  end

  // valid bits travel with the items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[FWD_LAT-1:0], in_fire};
      out_vld_r <= vld_r[FWD_LAT];
    end
  end

  tac_fwd #(.ADC_BITS(ADC_BITS)) u_fwd (
    .clk(clk), .en(en), .code(code_r), .b_coef(b_r), .value(val_f), .err(err_f)
  );

  tac_inv #(.ADC_BITS(ADC_BITS)) u_inv (
    .clk(clk), .en(en), .temp(temp_r), .b_coef(b_r), .value(val_i)
  );
  tac_dly #(.W(VAL_W), .N(FWD_LAT - INV_LAT)) u_pad (
    .clk(clk), .en(en), .d(val_i), .q(val_id)
  );

  tac_dly #(.W(1), .N(FWD_LAT)) u_func (
    .clk(clk), .en(en), .d(func_r), .q(func_d)
  );

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      value_r <= func_d ? val_id : val_f;
      err_r   <= !func_d && err_f;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.value = value_r;
  assign out_ch.error = err_r;

  // checks
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline valid bits moved during a stall");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> vld_r[0])
    else $error("accepted item not marked valid in the input register");

  a_err_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && err_r |-> value_r == VAL_ERR)
    else $error("error flag without the error value");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_vld_r && (vld_r == '0))
    else $error("valid bits not cleared by reset");

endmodule

`default_nettype wire
